[rtl/tsa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_pkg: shared types and constants of the task slot allocator
// Request and response beat layouts, command and status codes, pool size.
// ----------------------------------------------------------------------------
package tsa_pkg;

    // Default pool size
    localparam int POOL_SLOTS_DEF = 64;

    // Fixed field widths
    localparam int CFG_W   = 7;
    localparam int INDEX_W = 6;
    localparam int GEN_W   = 32;
    localparam int COUNT_W = 7;

    // Commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    // Active slots after reset
    localparam logic [CFG_W-1:0] ACTIVE_RESET = 7'd64;

    typedef struct packed {
        logic               cmd;
        logic [INDEX_W-1:0] free_index;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [INDEX_W-1:0] slot_index;
        logic [GEN_W-1:0]   generation;
        logic [COUNT_W-1:0] in_use;
    } rsp_t;

endpackage

[rtl/tsa_find_free.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_find_free: lowest free slot search
// Masks the busy map to the active slots and priority-encodes the lowest
// free one.
// ----------------------------------------------------------------------------
module tsa_find_free
    import tsa_pkg::*;
#(
    parameter int TRACK = 64
)
(
    input  logic [TRACK-1:0]         busy_map,
    input  logic [CFG_W-1:0]         limit,
    output logic                     found,
    output logic [$clog2(TRACK)-1:0] index
);

    logic [TRACK-1:0] avail;

    // Mark slots that are free and below the active limit
    always_comb
    begin
        for (int i = 0; i < TRACK; i++)
        begin
            avail[i] = !busy_map[i] && (i < int'(limit));
        end
    end

    // Pick the lowest available slot
    always_comb
    begin
        index = '0;
        for (int i = TRACK - 1; i >= 0; i--)
        begin
            if (avail[i])
            begin
                index = ($clog2(TRACK))'(i);
            end
        end
    end

    assign found = |avail;

endmodule

[rtl/task_slot_allocator_with_generation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_slot_allocator_with_generation: generational task slot allocator
// Hands out handles (generation, slot index) from a fixed slot pool and
// takes them back, keeping a use count and a nonzero running generation.
//
// Channel   Direction  Handshake                    Beat
// request   in         start && !busy               req   (cmd, free_index)
// response  out        done, one cycle, no stall    rsp   (status, slot_index,
//                                                          generation, in_use)
// config    in         cfg_we                       cfg_wdata (active_slots)
//
// A request beat is registered in req_reg when it is accepted, and its
// response is formed from req_reg and registered in rsp_reg with done.
// One request is accepted every cycle; busy stays low since the slot map
// and counters update in the same cycle the response is formed.
// The lowest free slot is found by a single priority encoder over the
// busy map. Reset frees every slot, sets the generation to 1 and the
// active count to 64. The receiver cannot stall responses.
// ----------------------------------------------------------------------------
module task_slot_allocator_with_generation
    import tsa_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  req_t             req,
    output logic             done,
    output rsp_t             rsp,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    // Only slots below 128 can ever be reached by a 7-bit active count
    localparam int TRACK      = (POOL_SLOTS < 128) ? POOL_SLOTS : 128;
    localparam int IDX_W      = $clog2(TRACK);
    localparam int PAD_W      = (TRACK < 64) ? 64 : TRACK;
    localparam int PAD_IDX_W  = $clog2(PAD_W);

    logic                 req_valid_reg;
    req_t                 req_reg;
    logic                 done_reg;
    rsp_t                 rsp_reg;
    rsp_t                 rsp_next;
    logic [TRACK-1:0]     busy_map_reg;
    logic [TRACK-1:0]     busy_map_next;
    logic [GEN_W-1:0]     next_gen_reg;
    logic [GEN_W-1:0]     next_gen_next;
    logic [COUNT_W-1:0]   used_count_reg;
    logic [COUNT_W-1:0]   used_count_next;
    logic [CFG_W-1:0]     active_reg;
    logic [CFG_W-1:0]     limit;
    logic                 alloc_found;
    logic [IDX_W-1:0]     alloc_index;
    logic [PAD_W-1:0]     pad_map;
    logic                 free_ok;
    logic                 alloc_ok;
    logic [GEN_W-1:0]     gen_inc;

    assign busy = 1'b0;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Clamp the active count to the pool
    always_comb
    begin
        if (int'(active_reg) > POOL_SLOTS)
        begin
            limit = CFG_W'(TRACK);
        end
        else
        begin
            limit = active_reg;
        end
    end

    tsa_find_free #(
        .TRACK (TRACK)
    ) u_find_free (
        .busy_map (busy_map_reg),
        .limit    (limit),
        .found    (alloc_found),
        .index    (alloc_index)
    );

    // Check the slot named by a free beat
    assign pad_map  = PAD_W'(busy_map_reg);
    assign free_ok  = (req_reg.cmd == CMD_FREE)
                      && (int'(req_reg.free_index) < int'(limit))
                      && pad_map[PAD_IDX_W'(req_reg.free_index)];
    assign alloc_ok = (req_reg.cmd == CMD_ALLOC) && alloc_found;

    // Advance the generation, skipping zero
    assign gen_inc = next_gen_reg + GEN_W'(1);

    // Form the response and the state update
    always_comb
    begin
        busy_map_next   = busy_map_reg;
        next_gen_next   = next_gen_reg;
        used_count_next = used_count_reg;
        rsp_next.status     = ST_OK;
        rsp_next.slot_index = '0;
        rsp_next.generation = '0;
        if (req_valid_reg)
        begin
            if (req_reg.cmd == CMD_ALLOC)
            begin
                if (alloc_ok)
                begin
                    for (int i = 0; i < TRACK; i++)
                    begin
                        if (alloc_index == IDX_W'(i))
                        begin
                            busy_map_next[i] = 1'b1;
                        end
                    end
                    rsp_next.slot_index = INDEX_W'(alloc_index);
                    rsp_next.generation = next_gen_reg;
                    next_gen_next       = (gen_inc == '0) ? GEN_W'(1) : gen_inc;
                    used_count_next     = used_count_reg + COUNT_W'(1);
                end
                else
                begin
                    rsp_next.status = ST_FULL;
                end
            end
            else
            begin
                if (free_ok)
                begin
                    for (int i = 0; i < TRACK; i++)
                    begin
                        if (PAD_IDX_W'(req_reg.free_index) == PAD_IDX_W'(i))
                        begin
                            busy_map_next[i] = 1'b0;
                        end
                    end
                    rsp_next.slot_index = req_reg.free_index;
                    used_count_next     = used_count_reg - COUNT_W'(1);
                end
                else
                begin
                    rsp_next.status = ST_BADFREE;
                end
            end
        end
        rsp_next.in_use = used_count_next;
    end

    // Hold control state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg  <= 1'b0;
            done_reg       <= 1'b0;
            busy_map_reg   <= '0;
            next_gen_reg   <= GEN_W'(1);
            used_count_reg <= '0;
            active_reg     <= ACTIVE_RESET;
        end
        else
        begin
            req_valid_reg  <= start && !busy;
            done_reg       <= req_valid_reg;
            busy_map_reg   <= busy_map_next;
            next_gen_reg   <= next_gen_next;
            used_count_reg <= used_count_next;
            if (cfg_we)
            begin
                active_reg <= cfg_wdata;
            end
        end
    end

    // Capture request and response beats
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= req;
        end
        if (req_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Every accepted beat yields one response, through req_valid_reg and done_reg
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("accepted request produced no response");

    // The use count tracks the busy map
    assert property (@(posedge clk) disable iff (!rst_n)
        used_count_reg == COUNT_W'($countones(busy_map_reg)))
        else $error("use count disagrees with busy map");

    // The running generation never reaches zero
    assert property (@(posedge clk) disable iff (!rst_n)
        next_gen_reg != '0)
        else $error("generation counter hit zero");

    // A failed request reports no slot and no generation
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status == ST_FULL || rsp.status == ST_BADFREE))
        |-> (rsp.slot_index == '0 && rsp.generation == '0))
        else $error("failed request reported a handle");

    // The state changes only when a request is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        !req_valid_reg |=> ($stable(busy_map_reg) && $stable(next_gen_reg)))
        else $error("slot state changed without a request");

endmodule
